@@ src/lpmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants of the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

  // default section capacities
  localparam int unsigned DefDestCapacity    = 32;
  localparam int unsigned DefLabelCapacity   = 32;
  localparam int unsigned DefContentCapacity = 1024;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 16;

  // section tag carried with every result word
  typedef enum logic [1:0] {
    SEC_DEST      = 2'd0,
    SEC_LABEL     = 2'd1,
    SEC_CONTENT   = 2'd2,
    SEC_EMPTY_END = 2'd3
  } section_e;

  // one result word
  typedef struct packed {
    section_e            section;
    logic [IndexW-1:0]   byte_index;
    logic [ByteW-1:0]    data_byte;
    logic                beyond_capacity;
    logic                message_end;
  } result_t;

endpackage

@@ src/lpmd_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module lpmd_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lpmd_pkg::ByteW-1:0] rx_byte_i,
  input  logic                       consume_i,
  output logic                       held_valid_o,
  output logic [lpmd_pkg::ByteW-1:0] held_byte_o
);
  import lpmd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             take;

  // stall only while a held word cannot move on
  assign in_stall_o = valid_q && !consume_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule

@@ src/lpmd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_parser
// Frame state machine: start byte hunt, header capture, section walk and
// tagging of each body byte.
// ----------------------------------------------------------------------------
module lpmd_parser #(
  parameter int unsigned DEST_CAPACITY    = lpmd_pkg::DefDestCapacity,
  parameter int unsigned LABEL_CAPACITY   = lpmd_pkg::DefLabelCapacity,
  parameter int unsigned CONTENT_CAPACITY = lpmd_pkg::DefContentCapacity
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lpmd_pkg::ByteW-1:0] byte_i,
  input  logic [lpmd_pkg::ByteW-1:0] start_delim_i,
  input  logic                       step_i,
  output logic                       has_result_o,
  output lpmd_pkg::result_t          result_o
);
  import lpmd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_DEST    = 3'd2,
    PH_LABEL   = 3'd3,
    PH_CONTENT = 3'd4
  } phase_e;

  localparam logic [IndexW-1:0] DestCap    = IndexW'(DEST_CAPACITY);
  localparam logic [IndexW-1:0] LabelCap   = IndexW'(LABEL_CAPACITY);
  localparam logic [IndexW-1:0] ContentCap = IndexW'(CONTENT_CAPACITY);

  phase_e              phase_q, phase_d;
  logic [1:0]          hdr_cnt_q, hdr_cnt_d;
  logic [ByteW-1:0]    dest_len_q, dest_len_d;
  logic [ByteW-1:0]    label_len_q, label_len_d;
  logic [IndexW-1:0]   content_len_q, content_len_d;
  logic [IndexW-1:0]   fill_q, fill_d;

  logic [IndexW-1:0]   sec_len;
  logic [IndexW-1:0]   sec_cap;
  logic [IndexW:0]     idx_next;
  logic                sec_done;
  result_t             res;
  logic                res_valid;

  // length and capacity of the current section
  always_comb begin
    case (phase_q)
      PH_DEST: begin
        sec_len = IndexW'(dest_len_q);
        sec_cap = DestCap;
      end
      PH_LABEL: begin
        sec_len = IndexW'(label_len_q);
        sec_cap = LabelCap;
      end
      default: begin
        sec_len = content_len_q;
        sec_cap = ContentCap;
      end
    endcase
  end

  assign idx_next = {1'b0, fill_q} + {{IndexW{1'b0}}, 1'b1};
  assign sec_done = idx_next >= {1'b0, sec_len};

  // next state and result word
  always_comb begin
    phase_d       = phase_q;
    hdr_cnt_d     = hdr_cnt_q;
    dest_len_d    = dest_len_q;
    label_len_d   = label_len_q;
    content_len_d = content_len_q;
    fill_d        = fill_q;
    res_valid     = 1'b0;
    res.section         = SEC_EMPTY_END;
    res.byte_index      = fill_q;
    res.data_byte       = byte_i;
    res.beyond_capacity = fill_q >= sec_cap;
    res.message_end     = 1'b0;

    case (phase_q)
      PH_HEADER: begin
        hdr_cnt_d = hdr_cnt_q + 2'd1;
        case (hdr_cnt_q)
          2'd0:    dest_len_d = byte_i;
          2'd1:    label_len_d = byte_i;
          2'd2:    content_len_d = {content_len_q[IndexW-1:ByteW], byte_i};
          default: begin
            content_len_d = {byte_i, content_len_q[ByteW-1:0]};
            fill_d        = '0;
            // enter the first non-empty section
            if (dest_len_q != '0) begin
              phase_d = PH_DEST;
            end else if (label_len_q != '0) begin
              phase_d = PH_LABEL;
            end else if (content_len_d != '0) begin
              phase_d = PH_CONTENT;
            end else begin
              phase_d             = PH_IDLE;
              res_valid           = 1'b1;
              res.section         = SEC_EMPTY_END;
              res.byte_index      = '0;
              res.data_byte       = '0;
              res.beyond_capacity = 1'b0;
              res.message_end     = 1'b1;
            end
          end
        endcase
      end
      PH_DEST, PH_LABEL, PH_CONTENT: begin
        res_valid = 1'b1;
        fill_d    = idx_next[IndexW-1:0];
        case (phase_q)
          PH_DEST:  res.section = SEC_DEST;
          PH_LABEL: res.section = SEC_LABEL;
          default:  res.section = SEC_CONTENT;
        endcase
        // section finished: skip empty sections that follow
        if (sec_done) begin
          fill_d = '0;
          if (phase_q == PH_DEST && label_len_q != '0) begin
            phase_d = PH_LABEL;
          end else if (phase_q != PH_CONTENT && content_len_q != '0) begin
            phase_d = PH_CONTENT;
          end else begin
            phase_d         = PH_IDLE;
            res.message_end = 1'b1;
          end
        end
      end
      default: begin
        // hunt for the start byte
        if (byte_i == start_delim_i) begin
          phase_d       = PH_HEADER;
          hdr_cnt_d     = '0;
          dest_len_d    = '0;
          label_len_d   = '0;
          content_len_d = '0;
          fill_d        = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      hdr_cnt_q     <= '0;
      dest_len_q    <= '0;
      label_len_q   <= '0;
      content_len_q <= '0;
      fill_q        <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      hdr_cnt_q     <= hdr_cnt_d;
      dest_len_q    <= dest_len_d;
      label_len_q   <= label_len_d;
      content_len_q <= content_len_d;
      fill_q        <= fill_d;
    end
  end

  assign has_result_o = res_valid;
  assign result_o     = res;

endmodule

@@ src/lpmd_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_out_stage
// Result register: holds one tagged word until the sink takes it.
// ----------------------------------------------------------------------------
module lpmd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lpmd_pkg::result_t result_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpmd_pkg::result_t result_o
);
  import lpmd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // free when empty or draining this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

@@ src/length_prefixed_message_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Parses start byte, four-byte length header and tagged body words.
// ----------------------------------------------------------------------------
// With the sink not stalling, takes one byte per clock and sustains one word
// per cycle. A byte passes through an input register and then a result
// register before its word is offered on the output. Outside a frame every
// byte but the start byte is dropped. The header is destination length, label
// length and a little-endian 16-bit content length; each body byte then comes
// out tagged with its section and index, flagged when the index reaches the
// section capacity, and the last one marked with message_end. An all-zero
// header gives a single end word with section 3. The start byte register may
// only be written while no frame word is in flight.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer #(
  parameter int unsigned DEST_CAPACITY    = lpmd_pkg::DefDestCapacity,
  parameter int unsigned LABEL_CAPACITY   = lpmd_pkg::DefLabelCapacity,
  parameter int unsigned CONTENT_CAPACITY = lpmd_pkg::DefContentCapacity
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lpmd_pkg::ByteW-1:0]  cfg_data_i,
  // byte input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lpmd_pkg::ByteW-1:0]  rx_byte_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  section_o,
  output logic [lpmd_pkg::IndexW-1:0] byte_index_o,
  output logic [lpmd_pkg::ByteW-1:0]  data_byte_o,
  output logic                        beyond_capacity_o,
  output logic                        message_end_o
);
  import lpmd_pkg::*;

  logic             cfg_write;
  logic [ByteW-1:0] start_byte_q;
  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             has_result;
  logic             out_ready;
  logic             step;
  result_t          parsed;
  result_t          out_word;

  // start byte register, always writable
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= '0;
    end else if (cfg_write) begin
      start_byte_q <= cfg_data_i;
    end
  end

  // a held word moves on unless its result has nowhere to go
  assign step = held_valid && (!has_result || out_ready);

  lpmd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .consume_i    (step),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  lpmd_parser #(
    .DEST_CAPACITY    (DEST_CAPACITY),
    .LABEL_CAPACITY   (LABEL_CAPACITY),
    .CONTENT_CAPACITY (CONTENT_CAPACITY)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_i        (held_byte),
    .start_delim_i (start_byte_q),
    .step_i        (step),
    .has_result_o  (has_result),
    .result_o      (parsed)
  );

  lpmd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && has_result),
    .result_i    (parsed),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_word)
  );

  assign section_o         = out_word.section;
  assign byte_index_o      = out_word.byte_index;
  assign data_byte_o       = out_word.data_byte;
  assign beyond_capacity_o = out_word.beyond_capacity;
  assign message_end_o     = out_word.message_end;

endmodule

@@ src/lpmd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module lpmd_checker #(
  parameter int unsigned DEST_CAPACITY    = lpmd_pkg::DefDestCapacity,
  parameter int unsigned LABEL_CAPACITY   = lpmd_pkg::DefLabelCapacity,
  parameter int unsigned CONTENT_CAPACITY = lpmd_pkg::DefContentCapacity
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  section_o,
  input logic [lpmd_pkg::IndexW-1:0] byte_index_o,
  input logic [lpmd_pkg::ByteW-1:0]  data_byte_o,
  input logic                        beyond_capacity_o,
  input logic                        message_end_o
);
  import lpmd_pkg::*;

  localparam logic [IndexW-1:0] DestCap    = IndexW'(DEST_CAPACITY);
  localparam logic [IndexW-1:0] LabelCap   = IndexW'(LABEL_CAPACITY);
  localparam logic [IndexW-1:0] ContentCap = IndexW'(CONTENT_CAPACITY);

  // a stalled word stays offered
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // empty message end word is all zero and marked last
  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && section_o == SEC_EMPTY_END |->
      message_end_o && byte_index_o == '0 && data_byte_o == '0 && !beyond_capacity_o)
    else $error("malformed empty message end word");

  // capacity flag follows the index in short sections
  a_short_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (section_o == SEC_DEST || section_o == SEC_LABEL) |->
      beyond_capacity_o == (byte_index_o >= ((section_o == SEC_DEST) ? DestCap : LabelCap)))
    else $error("capacity flag wrong in destination or label");

  // capacity flag follows the index in content
  a_content_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && section_o == SEC_CONTENT |->
      beyond_capacity_o == (byte_index_o >= ContentCap))
    else $error("capacity flag wrong in content");

endmodule

bind length_prefixed_message_deframer lpmd_checker #(
  .DEST_CAPACITY    (DEST_CAPACITY),
  .LABEL_CAPACITY   (LABEL_CAPACITY),
  .CONTENT_CAPACITY (CONTENT_CAPACITY)
) u_lpmd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .section_o         (section_o),
  .byte_index_o      (byte_index_o),
  .data_byte_o       (data_byte_o),
  .beyond_capacity_o (beyond_capacity_o),
  .message_end_o     (message_end_o)
);
